@@ rtl/srl_pkg.sv @@
// ----------------------------------------------------------------------------
// srl_pkg
// Types, constants and helpers shared by the S-record line loader.
// ----------------------------------------------------------------------------
`default_nettype none

package srl_pkg;

   localparam int MAX_DATA_BYTES = 63;
   localparam int FILL_W         = 6;
   localparam int BUF_AW         = FILL_W + 1;
   localparam int BUF_DEPTH      = 1 << BUF_AW;

   localparam logic [7:0] TYPE_DATA    = 8'h32;
   localparam logic [7:0] TYPE_TRAILER = 8'h38;
   localparam logic [9:0] POS_LIMIT    = 10'd1023;
   localparam logic [7:0] MIN_COUNT    = 8'd3;
   localparam logic [7:0] HDR_BYTES    = 8'd4;
   localparam logic [7:0] SUM_GOOD     = 8'hFF;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_TYPE  = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd2;
   localparam logic [2:0] STATUS_BAD_SUM   = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

   localparam logic KIND_WRITE     = 1'b0;
   localparam logic KIND_HANDSHAKE = 1'b1;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [23:0] address;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic        is_trailer;
      logic [15:0] good_records;
      logic        progress_mark;
      logic        last;
   } rsp_type;

   // one finished line, handed from front to back
   typedef struct packed {
      logic [2:0]        status;
      logic              trailer;
      logic [23:0]       address;
      logic [FILL_W-1:0] n_writes;
      logic [15:0]       good;
      logic              mark;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
      logic [7:0]        data;
   } bufwr_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
      else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/srecord_line_loader.sv @@
// ----------------------------------------------------------------------------
// srecord_line_loader
// S2/S8 S-record line loader.
//
// Request channel: one character per request, starting after the leading
// 'S'; end_of_line marks the last character. Characters are taken one per
// cycle while fewer than two finished lines are queued.
// Response channel: for an accepted S2 line, one memory write per data
// byte, then one handshake per line (status, record count, progress mark,
// entry address for an accepted S8) flagged with last.
// Draining: a finished line's descriptor is registered in the queue; the
// result sequencer then does a buffer read, then an output load, for each
// write, and a single output load for the handshake. While a line drains,
// the next line is parsed into the other buffer bank.
// Reset: line state, record count and queue cleared; buffer left as is.
// A stalled response holds in the output register; the parser keeps
// running until both buffer banks hold finished lines.
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_line_loader (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  srl_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output srl_pkg::rsp_type  rsp_payload
);
   import srl_pkg::*;

   bufwr_type buf_wr;
   desc_type  push_desc, head;
   logic      push, pop, empty, full, wr_bank, rd_bank, req_fire;

   assign req_ready = !full;
   assign req_fire  = req_valid && req_ready;

   srl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .bank        (wr_bank),
      .buf_wr      (buf_wr),
      .push        (push),
      .push_desc   (push_desc)
   );

   srl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full),
      .wr_bank   (wr_bank),
      .rd_bank   (rd_bank)
   );

   srl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .buf_wr      (buf_wr),
      .head        (head),
      .empty       (empty),
      .rd_bank     (rd_bank),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ rtl/srl_front.sv @@
// ----------------------------------------------------------------------------
// srl_front
// Character parser: decodes type, count, address, data and checksum,
// writes data bytes to the line buffer and classifies the line at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_fire,
   input  srl_pkg::req_type     req_payload,
   input  wire                  bank,
   output srl_pkg::bufwr_type   buf_wr,
   output logic                 push,
   output srl_pkg::desc_type    push_desc
);
   import srl_pkg::*;

   logic [9:0]        pos_ff, pos_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        count_ff, count_in;
   logic [23:0]       addr_ff, addr_in;
   logic [7:0]        sum_ff, sum_in;
   logic [3:0]        nib_ff, nib_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       acc_ff, acc_in;

   logic [3:0] hex;
   logic [7:0] byte_val;
   logic [8:0] k;
   logic       adv, take, wr_en, ok, is_data;
   logic [2:0] status;
   logic [9:0] want_len;

   always_comb begin
      hex      = hex_value(req_payload.ch);
      byte_val = {nib_ff, hex};
      adv      = pos_ff != POS_LIMIT;
      k        = pos_ff[9:1] - 9'd1;
      take     = adv && (pos_ff != 10'd0) && !pos_ff[0];

      type_in  = (adv && pos_ff == 10'd0) ? req_payload.ch : type_ff;
      nib_in   = (adv && pos_ff[0]) ? hex : nib_ff;
      sum_in   = take ? sum_ff + byte_val : sum_ff;
      count_in = (take && k == 9'd0) ? byte_val : count_ff;
      addr_in  = (take && k >= 9'd1 && k <= 9'd3) ? {addr_ff[15:0], byte_val} : addr_ff;
      wr_en    = take && (k >= 9'(HDR_BYTES)) && (k < {1'b0, count_ff})
                 && (k < 9'(MAX_DATA_BYTES + 4)) && (fill_ff < FILL_W'(MAX_DATA_BYTES));
      fill_in  = wr_en ? fill_ff + FILL_W'(1) : fill_ff;
      pos_in   = adv ? pos_ff + 10'd1 : pos_ff;

      want_len = {1'b0, count_in, 1'b0} + 10'd3;
      is_data  = type_in == TYPE_DATA;
      if (!is_data && type_in != TYPE_TRAILER) status = STATUS_BAD_TYPE;
      else if (count_in < MIN_COUNT || pos_in != want_len) status = STATUS_BAD_LEN;
      else if (sum_in != SUM_GOOD) status = STATUS_BAD_SUM;
      else if (is_data && count_in > 8'(MAX_DATA_BYTES + 4)) status = STATUS_TOO_LONG;
      else status = STATUS_OK;
      ok     = status == STATUS_OK;
      acc_in = ok ? acc_ff + 16'd1 : acc_ff;
   end

   assign buf_wr.en   = req_fire && wr_en;
   assign buf_wr.addr = {bank, fill_ff};
   assign buf_wr.data = byte_val;

   assign push                = req_fire && req_payload.end_of_line;
   assign push_desc.status    = status;
   assign push_desc.trailer   = ok && !is_data;
   assign push_desc.address   = addr_in;
   assign push_desc.n_writes  = (ok && is_data) ? fill_in : '0;
   assign push_desc.good      = acc_in;
   assign push_desc.mark      = ok && (acc_in[1:0] == 2'd0);

   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff   <= '0;
         type_ff  <= '0;
         count_ff <= '0;
         addr_ff  <= '0;
         sum_ff   <= '0;
         nib_ff   <= '0;
         fill_ff  <= '0;
      end else if (req_fire) begin
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
         sum_ff   <= sum_in;
         nib_ff   <= nib_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (push) begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/srl_queue.sv @@
// ----------------------------------------------------------------------------
// srl_queue
// Two-entry line queue; each slot also owns one bank of the line buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  srl_pkg::desc_type  push_desc,
   input  wire                pop,
   output srl_pkg::desc_type  head,
   output logic               empty,
   output logic               full,
   output logic               wr_bank,
   output logic               rd_bank
);
   import srl_pkg::*;

   desc_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head    = slot_ff[rd_ptr_ff];
   assign empty   = count_ff == 2'd0;
   assign full    = count_ff == 2'd2;
   assign wr_bank = wr_ptr_ff;
   assign rd_bank = rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

@@ rtl/srl_back.sv @@
// ----------------------------------------------------------------------------
// srl_back
// Line buffer and result sequencer: drains buffered writes of a finished
// line, then the handshake, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_back (
   input  wire                  clock,
   input  wire                  reset,
   input  srl_pkg::bufwr_type   buf_wr,
   input  srl_pkg::desc_type    head,
   input  wire                  empty,
   input  wire                  rd_bank,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output srl_pkg::rsp_type     rsp_payload
);
   import srl_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_READ  = 4'b0010,
      B_WRITE = 4'b0100,
      B_HAND  = 4'b1000
   } bstate_type;

   logic [7:0]        data_mem [BUF_DEPTH];
   logic [7:0]        rd_q_ff;
   bstate_type        state_ff, state_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              out_free, load;

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         data_mem[buf_wr.addr] <= buf_wr.data;
      end
      rd_q_ff <= data_mem[{rd_bank, idx_ff}];
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      load     = 1'b0;
      pop      = 1'b0;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         B_IDLE: begin
            idx_in = '0;
            if (!empty) begin
               state_in = (head.n_writes != '0) ? B_READ : B_HAND;
            end
         end
         B_READ: begin
            state_in = B_WRITE;
         end
         B_WRITE: begin
            if (out_free) begin
               load                 = 1'b1;
               rsp_in               = '0;
               rsp_in.kind          = KIND_WRITE;
               rsp_in.address       = head.address + 24'(idx_ff);
               rsp_in.data_byte     = rd_q_ff;
               if (idx_ff == head.n_writes - FILL_W'(1)) begin
                  state_in = B_HAND;
               end else begin
                  idx_in   = idx_ff + FILL_W'(1);
                  state_in = B_READ;
               end
            end
         end
         B_HAND: begin
            if (out_free) begin
               load                 = 1'b1;
               pop                  = 1'b1;
               rsp_in               = '0;
               rsp_in.kind          = KIND_HANDSHAKE;
               rsp_in.address       = head.trailer ? head.address : 24'd0;
               rsp_in.status        = head.status;
               rsp_in.is_trailer    = head.trailer;
               rsp_in.good_records  = head.good;
               rsp_in.progress_mark = head.mark;
               rsp_in.last          = 1'b1;
               state_in             = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
